// File: design/b2da_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII formatter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef struct packed {
    logic load;
    logic shift;
    logic find;
    logic advance;
  } b2da_cmd_t;

  typedef struct packed {
    logic shift_done;
    logic last_char;
  } b2da_sts_t;

endpackage : b2da_pkg
`default_nettype wire

// File: design/b2da_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller: sequences load, bit-serial conversion, leading digit search
// and character emission for one item at a time.
// ----------------------------------------------------------------------------
module b2da_ctrl
  import b2da_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire b2da_sts_t sts,
  output b2da_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          cmd.advance = 1'b1;
          if (sts.last_char) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

endmodule : b2da_ctrl
`default_nettype wire

// File: design/b2da_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_dp
// Datapath: magnitude register, shift-and-add-3 BCD digit register,
// leading digit search and character selection.
// ----------------------------------------------------------------------------
module b2da_dp
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   in_is_signed,
  input  wire b2da_cmd_t              cmd,
  output b2da_sts_t                   sts,
  output logic [CHAR_W-1:0]           out_character,
  output logic                        out_last
);

  localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned IDXW = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int unsigned CNTW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] mag_r;
  logic [DIGIT_W-1:0]     bcd_r [NDIG];
  logic [DIGIT_W-1:0]     bcd_nxt [NDIG];
  logic [DIGIT_W-1:0]     adj [NDIG];
  logic [CNTW-1:0]        bitcnt_r;
  logic [IDXW-1:0]        idx_r;
  logic [IDXW-1:0]        msd;
  logic                   sign_pend_r;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag_in;

  assign neg    = in_is_signed & in_value[VALUE_WIDTH-1];
  assign mag_in = neg ? (~in_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_value;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
    bcd_nxt[0] = {adj[0][2:0], mag_r[VALUE_WIDTH-1]};
    for (int i = 1; i < NDIG; i++) begin
      bcd_nxt[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i] != '0) begin
        msd = IDXW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r       <= mag_in;
      sign_pend_r <= neg;
      bitcnt_r    <= CNTW'(VALUE_WIDTH - 1);
      for (int i = 0; i < NDIG; i++) begin
        bcd_r[i] <= '0;
      end
    end else if (cmd.shift) begin
      mag_r    <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
      bitcnt_r <= bitcnt_r - 1'b1;
      for (int i = 0; i < NDIG; i++) begin
        bcd_r[i] <= bcd_nxt[i];
      end
    end
    if (cmd.find) begin
      idx_r <= msd;
    end else if (cmd.advance) begin
      if (sign_pend_r) begin
        sign_pend_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign sts.shift_done = (bitcnt_r == '0);
  assign sts.last_char  = !sign_pend_r && (idx_r == '0);

  assign out_character = sign_pend_r ? CHAR_MINUS
                                     : (CHAR_ZERO | {2'b00, bcd_r[idx_r]});
  assign out_last      = sts.last_char;

endmodule : b2da_dp
`default_nettype wire

// File: design/binary_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Formats one binary word, signed or unsigned, as decimal ASCII text.
//
// The input channel takes in_value and in_is_signed. The result channel
// returns an item's characters, most significant first, with out_last on
// the final character. A negative signed value begins with '-'.
// One item is processed at a time. After an input item is accepted, the
// shift-and-add-3 converter takes in all VALUE_WIDTH bits, one bit per
// cycle, then a search state finds the leading digit, after which the
// characters follow one per cycle while out_stall is low. An item has at
// most 11 characters at the default width.
// in_stall is high from acceptance until the last character is taken.
// When the receiver raises out_stall, the current character holds.
// Reset returns the controller to idle and drops any item in progress.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   in_is_signed,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [CHAR_W-1:0]           out_character,
  output logic                        out_last
);

  b2da_cmd_t cmd;
  b2da_sts_t sts;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  b2da_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .in_value      (in_value),
    .in_is_signed  (in_is_signed),
    .cmd           (cmd),
    .sts           (sts),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef SYNTHESIS
  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("Output still valid after the last character was taken.");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("Input accepted while characters are pending.");

  a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_character == CHAR_MINUS)
      |=> (out_valid && out_character != CHAR_MINUS))
    else $error("Minus sign not followed by a digit.");

  a_accept_starts_conversion: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (!out_valid && in_stall))
    else $error("Conversion did not start after an accepted item.");
`endif

endmodule : binary_to_decimal_ascii
`default_nettype wire

// File: tb/sv/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Self-checking testbench for the binary to decimal ASCII formatter. A short
// table of directed words covers zero, the extremes and the most negative
// value. Random words of mixed shapes follow, sent in bursts against a
// receiver that stalls on a changing pattern. Every character is checked
// against the decimal text, from the table or derived, for each accepted item.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii
  import b2da_pkg::*;
();

  localparam int unsigned WORD_W        = 32;
  localparam int          DIRECTED_ROWS = 21;
  localparam int          RANDOM_WORDS  = 350;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic [WORD_W-1:0] in_value     = '0;
  logic              in_is_signed = 1'b0;
  logic              out_stall    = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [CHAR_W-1:0] out_character;
  logic              out_last;

  string             in_text = "";
  text_char_t        pending_chars[$];
  int                mismatches     = 0;
  int                words_sent     = 0;
  int                negatives_sent = 0;
  int                chars_checked  = 0;
  logic [8:0]        stall_phase    = '0;

  logic [WORD_W-1:0] dir_word [DIRECTED_ROWS] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0009, 32'h0000_000A,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'h7FFF_FFFF, 32'd99, 32'd100, 32'd999999999, 32'd1000000000,
    32'hFFFF_FFF6, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF7,
    32'hF000_0000
  };
  logic dir_sgn [DIRECTED_ROWS] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b1
  };
  string dir_text [DIRECTED_ROWS] = '{
    "0", "0", "1", "9", "10", "4294967295", "-1", "-2147483648", "2147483648",
    "2147483647", "", "", "", "", "", "", "", "", "", "", ""
  };

  always #4 clk = ~clk;

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(WORD_W)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .in_is_signed (in_is_signed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  function automatic string decimal_text(input logic [WORD_W-1:0] word, input logic sgn);
    logic            neg;
    logic [WORD_W:0] mag;
    neg = sgn && word[WORD_W-1];
    mag = neg ? ({1'b0, ~word} + 1'b1) : {1'b0, word};
    return neg ? $sformatf("-%0d", mag) : $sformatf("%0d", mag);
  endfunction

  function automatic void queue_text(input string txt);
    text_char_t c;
    int         i;
    for (i = 0; i < txt.len(); i++) begin
      c.character = CHAR_W'(txt[i]);
      c.last      = (i == txt.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] p;
    int                k;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 999);
      2: return $urandom >> $urandom_range(0, 31);
      3: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      4: return WORD_W'(0 - $urandom_range(1, 1000));
      default: return {1'b1, 31'($urandom)};
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] error: %s", $time, what);
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && in_valid && !in_stall) begin
      words_sent++;
      if (in_is_signed && in_value[WORD_W-1]) negatives_sent++;
      if (in_text.len() != 0) queue_text(in_text);
      else queue_text(decimal_text(in_value, in_is_signed));
    end
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("character %0d with nothing expected", out_character));
      end else begin
        want = pending_chars.pop_front();
        if (out_character !== want.character)
          report_mismatch($sformatf("character %0d, expected %0d", out_character,
                                    want.character));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_last, want.last));
      end
    end
  end

  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[8:7])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= (stall_phase[2:0] < 3'd5);
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic send_word(input logic [WORD_W-1:0] word, input logic sgn, input string txt);
    in_valid     <= 1'b1;
    in_value     <= word;
    in_is_signed <= sgn;
    in_text      <= txt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  initial begin
    int i;
    int sent;
    int burst;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_word(dir_word[i], dir_sgn[i], dir_text[i]);
      if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 6));
    end
    wait_drained();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        send_word(random_word(), 1'($urandom_range(0, 1)), "");
        sent++;
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
      else if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 20));
    end

    wait_drained();
    repeat (60) @(negedge clk);
    $display("Sent %0d words (%0d negative), checked %0d characters, %0d errors.",
             words_sent, negatives_sent, chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii: match");
    end else begin
      $display("binary_to_decimal_ascii: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d characters still expected.", pending_chars.size());
    $display("binary_to_decimal_ascii: mismatch");
    $finish;
  end

endmodule

// File: sim.f
design/b2da_pkg.sv
design/b2da_ctrl.sv
design/b2da_dp.sv
design/binary_to_decimal_ascii.sv
tb/sv/tb_binary_to_decimal_ascii.sv
